FILE: sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/ebmlhp_pkg.sv
// ----------------------------------------------------------------------------
// ebmlhp_pkg
// field widths, status codes and result layout of the element header parser
// ----------------------------------------------------------------------------
`default_nettype none

package ebmlhp_pkg;

	localparam int OFFSET_W = 48;
	localparam int ID_W     = 57;
	localparam int SIZE_W   = 56;
	localparam int LEN_W    = 57;
	localparam int STATUS_W = 3;
	localparam int BYTE_W   = 8;

	// input request: data_byte, start_offset, limit_offset
	localparam int IN_W  = BYTE_W + 2 * OFFSET_W;
	localparam int RES_BITS = ID_W + SIZE_W + 2 * OFFSET_W + LEN_W + STATUS_W;
	localparam int OUT_W = ((RES_BITS + 7) / 8) * 8;
	localparam int PAD_W = OUT_W - RES_BITS;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ID_LEAD      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SIZE_LEAD    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ID_PAST      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SIZE_PAST    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD_PAST = 3'd5;
	localparam logic [STATUS_W-1:0] ST_LIMIT_FILE   = 3'd6;

	// element_id in the lowest bits, pad in the highest
	typedef struct packed {
		logic [PAD_W-1:0]    pad;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    element_length;
		logic [OFFSET_W-1:0] payload_offset;
		logic [OFFSET_W-1:0] element_offset;
		logic [SIZE_W-1:0]   payload_size;
		logic [ID_W-1:0]     element_id;
	} result_t;

	// count of leading zero bits of a byte, 8 for a zero byte
	function automatic logic [3:0] lead_zeros(input logic [BYTE_W-1:0] b);
		logic [3:0] n;
		logic       hit;
		n = 4'd8;
		hit = 1'b0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!hit && b[i]) begin
				n = 4'(BYTE_W - 1 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: sv/ebml_element_header_parser.sv
// ----------------------------------------------------------------------------
// ebml_element_header_parser
// decodes ebml element id and payload size from a byte stream
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle. A byte flagged in s_tuser opens a new
// header and brings its start and limit offsets; the id and size vints are
// decoded byte by byte and at most one result leaves per header, either the
// decoded header or an error status; a header cut off by the next flagged
// byte gives none. Each request passes an input register and then the decode
// logic into the output register. A new byte is taken every cycle unless a
// result waits in the output register and the decode stage holds a byte, in
// which case the input side holds until m_tready frees the output register.
// After an error, bytes are dropped until the next flagged byte.
`default_nettype none

module ebml_element_header_parser #(
	parameter int MAX_VINT_BYTES = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_wr_en,
	input  wire [ebmlhp_pkg::OFFSET_W-1:0]    cfg_wr_data,   // file_size_bytes
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// data_byte, start_offset, limit_offset
	input  wire [ebmlhp_pkg::IN_W-1:0]        s_tdata,
	input  wire                               s_tuser,       // header_start
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// element_id, payload_size, element_offset, payload_offset,
	// element_length, status, zero pad
	output logic [ebmlhp_pkg::OUT_W-1:0]      m_tdata
);
	import ebmlhp_pkg::*;

	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_ID_REST    = 2'd1;
	localparam logic [1:0] PH_SIZE_FIRST = 2'd2;
	localparam logic [1:0] PH_SIZE_REST  = 2'd3;

	localparam int CUR_W = OFFSET_W + 1;
	localparam int SUM_W = SIZE_W + 2;

	// input register
	logic                vld_s1;
	logic [IN_W-1:0]     data_s1;
	logic                start_s1;

	// parser state
	logic [1:0]          phase_q, phase_d;
	logic [2:0]          brem_q, brem_d;
	logic [ID_W-1:0]     acc_q, acc_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic [OFFSET_W-1:0] hoff_q, hoff_d;
	logic [CUR_W-1:0]    cursor_q, cursor_d;
	logic [OFFSET_W-1:0] limit_q, limit_d;
	logic [OFFSET_W-1:0] file_size_q;

	logic                out_vld_q;
	result_t             out_q;

	logic                adv;
	logic                res_vld;
	result_t             res;

	logic [BYTE_W-1:0]   b;
	logic [OFFSET_W-1:0] soff, loff, hoff_sel, lim_sel;
	logic [3:0]          lz;
	logic                bad_lead;
	logic [BYTE_W-1:0]   masked_b;
	logic [CUR_W-1:0]    cur_inc;
	logic [ID_W-1:0]     acc_shift;
	logic [SIZE_W-1:0]   size_val;
	logic                cur_past;
	logic                pay_past;
	logic [LEN_W-1:0]    elen;

	assign b    = data_s1[BYTE_W-1:0];
	assign soff = data_s1[BYTE_W +: OFFSET_W];
	assign loff = data_s1[BYTE_W + OFFSET_W +: OFFSET_W];

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	assign hoff_sel = start_s1 ? soff : hoff_q;
	assign lim_sel  = start_s1 ? loff : limit_q;
	assign cur_inc  = (start_s1 ? {1'b0, soff} : cursor_q) + CUR_W'(1);

	assign lz       = lead_zeros(b);
	assign bad_lead = (lz >= 4'd8) || ((32'(lz) + 32'd1) > 32'(MAX_VINT_BYTES));
	assign masked_b = BYTE_W'(8'hff >> (lz + 4'd1));
	assign acc_shift = {acc_q[ID_W-BYTE_W-1:0], b};

	// size in hand when the size field closes on this byte
	assign size_val = (phase_q == PH_SIZE_FIRST) ? SIZE_W'(b & masked_b)
		: acc_shift[SIZE_W-1:0];
	assign cur_past = cur_inc > {1'b0, lim_sel};
	assign pay_past = (SUM_W'(cur_inc) + SUM_W'(size_val)) > SUM_W'(lim_sel);
	assign elen     = LEN_W'(cur_inc - {1'b0, hoff_sel}) + LEN_W'(size_val);

	always_comb begin
		phase_d  = phase_q;
		brem_d   = brem_q;
		acc_d    = acc_q;
		id_d     = id_q;
		hoff_d   = hoff_q;
		cursor_d = cursor_q;
		limit_d  = limit_q;
		res_vld  = 1'b0;
		res      = '0;
		res.element_offset = hoff_sel;

		if (adv) begin
			if (start_s1) begin
				hoff_d   = soff;
				limit_d  = loff;
				cursor_d = cur_inc;
				brem_d   = 3'd0;
				phase_d  = PH_IDLE;
				if (file_size_q < loff) begin
					res_vld    = 1'b1;
					res.status = ST_LIMIT_FILE;
				end else if (bad_lead) begin
					res_vld    = 1'b1;
					res.status = ST_ID_LEAD;
				end else begin
					acc_d = ID_W'(b);
					if (lz == 4'd0) begin
						id_d = ID_W'(b);
						if (cur_past) begin
							res_vld    = 1'b1;
							res.status = ST_ID_PAST;
						end else begin
							phase_d = PH_SIZE_FIRST;
						end
					end else begin
						brem_d  = lz[2:0];
						phase_d = PH_ID_REST;
					end
				end
			end else begin
				unique case (phase_q)
					PH_ID_REST, PH_SIZE_REST: begin
						cursor_d = cur_inc;
						acc_d    = acc_shift;
						brem_d   = brem_q - 3'd1;
						if (brem_q == 3'd1) begin
							phase_d = PH_IDLE;
							if (phase_q == PH_ID_REST) begin
								id_d = acc_shift;
								if (cur_past) begin
									res_vld    = 1'b1;
									res.status = ST_ID_PAST;
								end else begin
									phase_d = PH_SIZE_FIRST;
								end
							end else begin
								res_vld = 1'b1;
								if (cur_past) begin
									res.status = ST_SIZE_PAST;
								end else if (pay_past) begin
									res.status = ST_PAYLOAD_PAST;
								end else begin
									res.status         = ST_OK;
									res.element_id     = id_q;
									res.payload_size   = size_val;
									res.payload_offset = cur_inc[OFFSET_W-1:0];
									res.element_length = elen;
								end
							end
						end
					end
					PH_SIZE_FIRST: begin
						cursor_d = cur_inc;
						phase_d  = PH_IDLE;
						if (bad_lead) begin
							res_vld    = 1'b1;
							res.status = ST_SIZE_LEAD;
						end else begin
							acc_d = ID_W'(b & masked_b);
							if (lz == 4'd0) begin
								res_vld = 1'b1;
								if (cur_past) begin
									res.status = ST_SIZE_PAST;
								end else if (pay_past) begin
									res.status = ST_PAYLOAD_PAST;
								end else begin
									res.status         = ST_OK;
									res.element_id     = id_q;
									res.payload_size   = size_val;
									res.payload_offset = cur_inc[OFFSET_W-1:0];
									res.element_length = elen;
								end
							end else begin
								brem_d  = lz[2:0];
								phase_d = PH_SIZE_REST;
							end
						end
					end
					PH_IDLE: begin
						// stray byte, nothing open
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			phase_q     <= PH_IDLE;
			brem_q      <= 3'd0;
			file_size_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			phase_q <= phase_d;
			brem_q  <= brem_d;
			if (cfg_wr_en) begin
				file_size_q <= cfg_wr_data;
			end
			if (adv && res_vld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
		acc_q    <= acc_d;
		id_q     <= id_d;
		hoff_q   <= hoff_d;
		cursor_q <= cursor_d;
		limit_q  <= limit_d;
		if (adv && res_vld) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

FILE: sv/ebmlhp_checker.sv
// ----------------------------------------------------------------------------
// ebmlhp_checker
// port-level checks on the element header parser results
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ebmlhp_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [ebmlhp_pkg::OUT_W-1:0]  m_tdata
);
	import ebmlhp_pkg::*;

	result_t             r;
	logic                ok;
	logic                err;
	logic [OFFSET_W-1:0] hdr_len;
	logic                hdr_len_ok;
	logic                fields_zero;

	assign r   = m_tdata;
	assign ok  = m_tvalid && (r.status == ST_OK);
	assign err = m_tvalid && (r.status != ST_OK);

	assign hdr_len     = r.payload_offset - r.element_offset;
	assign hdr_len_ok  = (hdr_len >= OFFSET_W'(2)) && (hdr_len <= OFFSET_W'(16));
	assign fields_zero = (r.element_id == '0) && (r.payload_size == '0)
		&& (r.payload_offset == '0) && (r.element_length == '0);

	// a stalled result stays offered
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	`ASSERT_IMPL(a_status_range, clk, arst_n, m_tvalid, r.status <= ST_LIMIT_FILE)

	// error results carry only the header offset
	`ASSERT_IMPL(a_err_zero, clk, arst_n, err, fields_zero)

	// header takes two to sixteen bytes
	`ASSERT_IMPL(a_hdr_len, clk, arst_n, ok, hdr_len_ok)

	`ASSERT_IMPL(a_elen, clk, arst_n, ok, r.element_length == (LEN_W'(r.payload_size) + LEN_W'(hdr_len)))

endmodule

bind ebml_element_header_parser ebmlhp_checker u_ebmlhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/ebml_element_header_parser_tb.sv
// ----------------------------------------------------------------------------
// ebml_element_header_parser_tb
// self-checking bench for the ebml element header parser
// ----------------------------------------------------------------------------
// Byte requests go in on the slave stream and every decoded header or error
// leaves on the master stream. A behavioral decoder follows each accepted
// byte and queues the header it expects; every result is checked field by
// field against the oldest one. Directed headers come first, then random
// well-formed headers mixed with broken ones and noise under several file
// sizes, with bursty input and a stalling receiver.
`timescale 1ns / 1ps
`default_nettype none

module ebml_element_header_parser_tb;
	import ebmlhp_pkg::*;

	localparam logic [47:0] OFF_MAX        = '1;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          RX_HOLD_CYCLES = 120;
	localparam int          WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ID_REST,
		PH_SIZE_FIRST,
		PH_SIZE_REST
	} parse_phase_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [OFFSET_W-1:0] cfg_wr_data = '0;
	logic                s_tvalid    = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata     = '0;
	logic                s_tuser     = 1'b0;
	logic                m_tvalid;
	logic                m_tready    = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// decoder state
	parse_phase_t ph         = PH_IDLE;
	int unsigned  bytes_left = 0;
	logic [63:0]  acc        = '0;
	logic [63:0]  held_id    = '0;
	logic [63:0]  hdr_off    = '0;
	logic [63:0]  cur        = '0;
	logic [63:0]  lim        = '0;
	logic [63:0]  file_size  = '0;

	result_t     expected_headers[$];
	logic [7:0]  hdr_bytes[$];
	int unsigned items_taken = 0;
	int unsigned fail_cnt    = 0;
	int unsigned burst_left  = 0;
	int unsigned idle_cycles = 0;

	logic        rx_hold      = 1'b0;
	int unsigned rx_mode      = 0;
	int unsigned rx_mode_left = 0;
	int unsigned rx_tick      = 0;
	event        rx_hold_go;

	always #1 clk = ~clk;

	ebml_element_header_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),     // data_byte, start_offset, limit_offset
		.s_tuser     (s_tuser),     // header_start
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)      // element_id, payload_size, element_offset,
		                            // payload_offset, element_length, status
	);

	function automatic logic [3:0] zeros_above(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		while (n < 4'd8 && !b[7 - n])
			n++;
		return n;
	endfunction

	function automatic void close_header(output result_t r, input logic [63:0] id, sz,
			poff, elen, input logic [STATUS_W-1:0] st);
		r = '0;
		r.element_id     = id[ID_W-1:0];
		r.payload_size   = sz[SIZE_W-1:0];
		r.element_offset = hdr_off[OFFSET_W-1:0];
		r.payload_offset = poff[OFFSET_W-1:0];
		r.element_length = elen[LEN_W-1:0];
		r.status         = st;
		ph = PH_IDLE;
		bytes_left = 0;
	endfunction

	function automatic bit end_of_id(output result_t r);
		r = '0;
		held_id = acc;
		if (cur > lim) begin
			close_header(r, 0, 0, 0, 0, ST_ID_PAST);
			return 1'b1;
		end
		ph = PH_SIZE_FIRST;
		return 1'b0;
	endfunction

	function automatic bit end_of_size(output result_t r);
		r = '0;
		if (cur > lim) begin
			close_header(r, 0, 0, 0, 0, ST_SIZE_PAST);
			return 1'b1;
		end
		if (cur + acc > lim) begin
			close_header(r, 0, 0, 0, 0, ST_PAYLOAD_PAST);
			return 1'b1;
		end
		close_header(r, held_id, acc, cur, cur - hdr_off + acc, ST_OK);
		return 1'b1;
	endfunction

	// advances the decoder by one byte, returns 1 when a header result is due
	function automatic bit decode_header_byte(input logic [7:0] b, input logic hs,
			input logic [47:0] so, lo, output result_t r);
		logic [3:0] lz;
		r = '0;
		if (hs) begin
			hdr_off = {16'd0, so};
			lim = {16'd0, lo};
			cur = hdr_off;
			acc = '0;
			held_id = '0;
			bytes_left = 0;
			if (file_size < lim) begin
				close_header(r, 0, 0, 0, 0, ST_LIMIT_FILE);
				return 1'b1;
			end
			cur++;
			lz = zeros_above(b);
			if (lz >= 4'd8) begin
				close_header(r, 0, 0, 0, 0, ST_ID_LEAD);
				return 1'b1;
			end
			acc = {56'd0, b};
			if (lz == 4'd0)
				return end_of_id(r);
			bytes_left = int'(lz);
			ph = PH_ID_REST;
			return 1'b0;
		end
		case (ph)
			PH_ID_REST, PH_SIZE_REST: begin
				cur++;
				acc = {acc[55:0], b};
				if (bytes_left > 0)
					bytes_left--;
				if (bytes_left != 0)
					return 1'b0;
				if (ph == PH_ID_REST)
					return end_of_id(r);
				return end_of_size(r);
			end
			PH_SIZE_FIRST: begin
				cur++;
				lz = zeros_above(b);
				if (lz >= 4'd8) begin
					close_header(r, 0, 0, 0, 0, ST_SIZE_LEAD);
					return 1'b1;
				end
				// marker bit dropped from the size
				acc = {56'd0, b & (8'hff >> (lz + 4'd1))};
				if (lz == 4'd0)
					return end_of_size(r);
				bytes_left = int'(lz);
				ph = PH_SIZE_REST;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// follow accepted requests and register writes
	always @(posedge clk) begin : track_requests
		result_t r;
		if (arst_n) begin
			if (cfg_wr_en)
				file_size = {16'd0, cfg_wr_data};
			if (s_tvalid && s_tready) begin
				items_taken++;
				if (decode_header_byte(s_tdata[7:0], s_tuser, s_tdata[55:8],
						s_tdata[103:56], r))
					expected_headers.push_back(r);
			end
		end
	end

	task automatic compare_field(input string name, input logic [63:0] want, got);
		if (got !== want) begin
			$error("%s expected %h actual %h", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_headers.size() == 0) begin
				$error("result with no header pending, element_offset %h", got.element_offset);
				fail_cnt++;
			end else begin
				want = expected_headers.pop_front();
				compare_field("element_id", 64'(want.element_id), 64'(got.element_id));
				compare_field("payload_size", 64'(want.payload_size), 64'(got.payload_size));
				compare_field("element_offset", 64'(want.element_offset),
					64'(got.element_offset));
				compare_field("payload_offset", 64'(want.payload_offset),
					64'(got.payload_offset));
				compare_field("element_length", 64'(want.element_length),
					64'(got.element_length));
				compare_field("status", 64'(want.status), 64'(got.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always begin
		@(rx_hold_go);
		rx_hold = 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// receiver stall pattern, switching among four styles at random
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(50, 300);
		end
		rx_mode_left--;
		rx_tick++;
		if (rx_hold)
			m_tready <= 1'b0;
		else case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 1) == 0);
			default: m_tready <= (rx_tick % 7) > 2;
		endcase
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic logic [63:0] pick_offset();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 1000));
			1: return {16'd0, OFF_MAX} - 64'($urandom_range(0, 1000));
			default: return {16'd0, rand48()};
		endcase
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 8);
		return $urandom_range(1, 2);
	endfunction

	// content goes below the length marker
	function automatic void push_vint(input int len, input logic [63:0] content);
		logic [63:0] v;
		v = (content & ((64'd1 << (7 * len)) - 64'd1)) | (64'd1 << (7 * len));
		for (int i = len - 1; i >= 0; i--)
			hdr_bytes.push_back(v[8 * i +: 8]);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic hs, input logic [47:0] so, lo);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {lo, so, b};
		s_tuser <= hs;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_header(input logic [47:0] so, lo);
		foreach (hdr_bytes[i]) begin
			if (i == 0)
				send_byte(hdr_bytes[i], 1'b1, so, lo);
			else
				send_byte(hdr_bytes[i], 1'b0, rand48(), rand48());
		end
	endtask

	task automatic drain_wait();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_headers.size() != 0)
			@(posedge clk);
		// a partial header may still sit inside the block
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_file_size(input logic [47:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_header(input bit broken);
		int          id_len;
		int          sz_len;
		int          cut;
		logic [63:0] sz;
		logic [63:0] start;
		logic [63:0] stop;
		logic [63:0] lim_off;
		id_len = pick_len();
		sz_len = pick_len();
		sz = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
		sz &= (64'd1 << (7 * sz_len)) - 64'd1;
		hdr_bytes.delete();
		push_vint(id_len, {$urandom, $urandom});
		push_vint(sz_len, sz);
		start = pick_offset();
		stop = start + id_len + sz_len + sz;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: lim_off = stop + $urandom_range(0, 3);
			6: lim_off = stop - $urandom_range(1, 3);
			7: lim_off = start + $urandom_range(0, id_len + sz_len);
			8: lim_off = {16'd0, OFF_MAX};
			default: lim_off = {16'd0, rand48()};
		endcase
		if (lim_off > {16'd0, OFF_MAX})
			lim_off = {16'd0, OFF_MAX};
		if (broken) begin
			case ($urandom_range(0, 2))
				0: hdr_bytes[0] = 8'h00;
				1: hdr_bytes[id_len] = 8'h00;
				default: begin
					// truncated, the next start cuts it off
					cut = $urandom_range(1, hdr_bytes.size() - 1);
					while (hdr_bytes.size() > cut)
						void'(hdr_bytes.pop_back());
				end
			endcase
		end
		send_header(start[47:0], lim_off[47:0]);
	endtask

	task automatic test_directed_headers();
		write_file_size(OFF_MAX);
		hdr_bytes = '{8'h80, 8'h81};
		send_header(48'd0, OFF_MAX);
		send_byte(8'h55, 1'b0, rand48(), rand48());     // no header open
		hdr_bytes = '{8'h00};
		send_header(48'd7, OFF_MAX);
		send_byte(8'hff, 1'b0, rand48(), rand48());     // dropped after error
		hdr_bytes = '{8'hff, 8'h00};
		send_header(48'd7, OFF_MAX);
		hdr_bytes = '{8'h81};
		send_header(48'd10, 48'd10);
		hdr_bytes = '{8'h81, 8'h80};
		send_header(48'd10, 48'd11);
		hdr_bytes = '{8'h81, 8'h82};
		send_header(48'd10, 48'd13);
		hdr_bytes = '{8'h10, 8'h00};
		send_header(48'd3, OFF_MAX);
		hdr_bytes = '{8'h40, 8'h01, 8'h42, 8'h34};
		send_header(48'd5, OFF_MAX);
		hdr_bytes = '{8'h80};
		send_header(OFF_MAX, OFF_MAX);
		hdr_bytes = '{8'h80, 8'hff};
		send_header(OFF_MAX - 48'd3, OFF_MAX);
		hdr_bytes = '{8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80};
		send_header(48'd0, OFF_MAX);
	endtask

	task automatic test_input_backpressure();
		drain_wait();
		-> rx_hold_go;
		repeat (20)
			random_header(1'b0);
		drain_wait();
	endtask

	task automatic test_limit_over_file();
		drain_wait();
		write_file_size(48'd100);
		hdr_bytes = '{8'h80};
		send_header(48'd0, 48'd101);
		hdr_bytes = '{8'h80, 8'h80};
		send_header(48'd98, 48'd100);
	endtask

	task automatic test_random_traffic(input logic [47:0] fsize_val, input int unsigned count);
		int unsigned goal;
		drain_wait();
		write_file_size(fsize_val);
		goal = items_taken + count;
		while (items_taken < goal) begin
			case ($urandom_range(0, 9))
				0: random_header(1'b1);
				1: send_byte(8'($urandom), $urandom_range(0, 3) == 0, rand48(), rand48());
				2: repeat ($urandom_range(1, 3))
					send_byte(8'($urandom), 1'b0, rand48(), rand48());
				default: random_header(1'b0);
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_headers();
		test_input_backpressure();
		test_limit_over_file();
		test_random_traffic(OFF_MAX, 250);
		test_random_traffic(rand48(), 100);
		test_random_traffic(48'd0, 60);
		test_random_traffic(48'($urandom_range(1, 100000)), 80);
		test_random_traffic(OFF_MAX, 150);
		drain_wait();
		if (expected_headers.size() != 0)
			$error("%0d headers never came out", expected_headers.size());
		if (fail_cnt == 0 && expected_headers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
